// ----- design/mfcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mfcc_pkg;
  localparam int MaxModules = 8;
  localparam int SlotW = $clog2(MaxModules);
  localparam int CountW = $clog2(MaxModules + 1);

  typedef enum logic [1:0] {
    REQ_FRAME  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_FRAME_ID   = 2'd0,
    CFG_CRC_LIMIT  = 2'd1,
    CFG_STALE      = 2'd2,
    CFG_CONSISTENT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CHK_OK           = 3'd0,
    CHK_INCONSISTENT = 3'd1,
    CHK_STALE        = 3'd2,
    CHK_NOT_VALID    = 3'd3,
    CHK_OFFLINE      = 3'd4,
    CHK_NO_MODULE    = 3'd5
  } chk_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CRC,
    ST_APPLY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic crc_step;
    logic apply;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic crc_done;
  } sts_t;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h07;
  localparam logic [7:0] SatMax = 8'd255;

  // Advance the CRC over one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int b = 0; b < 8; b++) begin
      if (r[7]) r = {r[6:0], 1'b0} ^ CrcPoly;
      else r = {r[6:0], 1'b0};
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/mfcc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mfcc_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [7:0] target_module;
  logic [10:0] frame_id;
  logic [3:0] frame_len;
  logic [63:0] payload;
  logic [31:0] time_now;
  modport source(output valid, req_type, target_module, frame_id, frame_len, payload,
    time_now, input ready);
  modport sink(input valid, req_type, target_module, frame_id, frame_len, payload,
    time_now, output ready);
endinterface

interface mfcc_rsp_if;
  logic valid;
  logic ready;
  logic ok;
  logic crc_ok;
  logic bytes_changed;
  logic [7:0] steady_count;
  logic cache_valid;
  logic [2:0] check_result;
  logic [3:0] module_count;
  modport source(output valid, ok, crc_ok, bytes_changed, steady_count, cache_valid,
    check_result, module_count, input ready);
  modport sink(input valid, ok, crc_ok, bytes_changed, steady_count, cache_valid,
    check_result, module_count, output ready);
endinterface
`default_nettype wire

// ----- design/mfcc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfcc_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire mfcc_pkg::sts_t sts,
  output mfcc_pkg::ctl_t ctl
);
  import mfcc_pkg::*;
  state_t state, state_next;
  logic out_valid_next;
  logic busy;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && in_ready) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_CRC;
      ST_CRC:    if (sts.crc_done) state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_OUT;
      ST_OUT:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl = '0;
    busy = (state != ST_IDLE);
    in_ready = !busy;
    ctl.load = (state == ST_IDLE) && in_valid;
    ctl.lookup = (state == ST_LOOKUP);
    ctl.crc_step = (state == ST_CRC);
    ctl.apply = (state == ST_APPLY);
    ctl.out_load = (state == ST_OUT) && (!out_valid || out_ready);
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (ctl.out_load) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_out_from_state: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> out_valid) else $error("result not raised");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_LOOKUP) else $error("accept lost");
  a_apply_once: assert property (@(posedge clk) disable iff (rst)
    ctl.apply |=> !ctl.apply) else $error("apply repeated");
endmodule
`default_nettype wire

// ----- design/mfcc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mfcc_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire mfcc_pkg::ctl_t ctl,
  output mfcc_pkg::sts_t sts,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] target_module,
  input  wire logic [10:0] frame_id,
  input  wire logic [3:0] frame_len,
  input  wire logic [63:0] payload,
  input  wire logic [31:0] time_now,
  output logic ok,
  output logic crc_ok,
  output logic bytes_changed,
  output logic [7:0] steady_count,
  output logic cache_valid,
  output logic [2:0] check_result,
  output logic [3:0] module_count
);
  import mfcc_pkg::*;

  logic [10:0] data_frame_id;
  logic [7:0] crc_error_limit;
  logic [31:0] stale_limit_ms;
  logic [7:0] consistent_needed;

  logic [MaxModules-1:0] slot_used, slot_valid, slot_online;
  logic [7:0] slot_module_id [MaxModules];
  logic [47:0] slot_bytes [MaxModules];
  logic [7:0] slot_consistent [MaxModules];
  logic [7:0] slot_crc_errors [MaxModules];
  logic [31:0] slot_update_time [MaxModules];
  logic [31:0] slot_rx_total [MaxModules];
  logic [31:0] slot_crc_total [MaxModules];
  logic [CountW-1:0] used_count;

  // Request copy
  logic [1:0] r_req;
  logic [7:0] r_target;
  logic r_fid_match;
  logic [3:0] r_len;
  logic [63:0] r_payload;
  logic [31:0] r_now;

  // Lookup results
  logic hit;
  logic [SlotW-1:0] hit_slot;
  logic has_free;
  logic [SlotW-1:0] free_slot;
  logic [3:0] crc_idx;
  logic [7:0] crc;

  logic [7:0] key;
  logic l_hit, l_free;
  logic [SlotW-1:0] l_hit_slot, l_free_slot;

  // Result computed by the update step, held until the output register is free
  logic res_ok, res_crc_ok, res_changed, res_cache_valid;
  logic [7:0] res_steady;
  logic [2:0] res_check;

  // Search the table
  always_comb begin
    key = (r_req == REQ_FRAME) ? r_payload[7:0] : r_target;
    l_hit = 1'b0;
    l_hit_slot = '0;
    l_free = 1'b0;
    l_free_slot = '0;
    for (int k = MaxModules - 1; k >= 0; k--) begin
      if (slot_used[k] && slot_module_id[k] == key) begin
        l_hit = 1'b1;
        l_hit_slot = SlotW'(k);
      end
      if (!slot_used[k]) begin
        l_free = 1'b1;
        l_free_slot = SlotW'(k);
      end
    end
  end

  // Done once every byte ahead of the CRC byte is folded in
  assign sts.crc_done = (crc_idx + 4'd1 >= r_len);

  logic [7:0] crc_byte;
  always_comb begin
    crc_byte = r_payload[{crc_idx[2:0], 3'b000} +: 8];
  end

  // Capture request and run CRC a byte a cycle
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_req <= req_type;
      r_target <= target_module;
      r_fid_match <= (frame_id == data_frame_id);
      r_len <= (frame_len > 4'd8) ? 4'd8 : frame_len;
      r_payload <= payload;
      r_now <= time_now;
      crc <= CrcInit;
      crc_idx <= '0;
    end
    if (ctl.lookup) begin
      hit <= l_hit;
      hit_slot <= l_hit_slot;
      has_free <= l_free;
      free_slot <= l_free_slot;
    end
    if (ctl.crc_step && !sts.crc_done) begin
      crc <= crc8_byte(crc, crc_byte);
      crc_idx <= crc_idx + 4'd1;
    end
  end

  // Apply stage
  logic [47:0] mask, fresh, old_bytes;
  logic [7:0] got;
  logic [2:0] dlen;
  logic frame_go, crc_good, changed;
  logic [7:0] cons_old, err_old, err_new, cons_new;
  logic [31:0] age;
  always_comb begin
    dlen = (r_len >= 4'd2) ? 3'(r_len - 4'd2) : 3'd0;
    mask = '0;
    for (int i = 0; i < 6; i++) if (3'(i) < dlen) mask[8*i +: 8] = 8'hFF;
    fresh = r_payload[55:8] & mask;
    got = r_payload[{3'(r_len - 4'd1), 3'b000} +: 8];
    frame_go = (r_req == REQ_FRAME) && r_fid_match && hit && (r_len >= 4'd2);
    crc_good = (got == crc);
    old_bytes = slot_bytes[hit_slot];
    changed = slot_valid[hit_slot] && (dlen != 3'd0) && (((old_bytes ^ fresh) & mask) != '0);
    cons_old = slot_consistent[hit_slot];
    cons_new = changed ? 8'd1 : ((cons_old < SatMax) ? cons_old + 8'd1 : cons_old);
    err_old = slot_crc_errors[hit_slot];
    err_new = (err_old < SatMax) ? err_old + 8'd1 : err_old;
    age = r_now - slot_update_time[hit_slot];
  end

  // Config registers and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      data_frame_id <= '0;
      crc_error_limit <= 8'd3;
      stale_limit_ms <= 32'd1000;
      consistent_needed <= 8'd3;
      slot_used <= '0;
      slot_valid <= '0;
      slot_online <= '0;
      used_count <= '0;
      ok <= 1'b0;
      crc_ok <= 1'b0;
      bytes_changed <= 1'b0;
      steady_count <= '0;
      cache_valid <= 1'b0;
      check_result <= CHK_OK;
      module_count <= '0;
      for (int k = 0; k < MaxModules; k++) begin
        slot_bytes[k] <= '0;
        slot_consistent[k] <= '0;
        slot_crc_errors[k] <= '0;
        slot_update_time[k] <= '0;
        slot_rx_total[k] <= '0;
        slot_crc_total[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FRAME_ID:   data_frame_id <= cfg_data[10:0];
          CFG_CRC_LIMIT:  crc_error_limit <= cfg_data[7:0];
          CFG_STALE:      stale_limit_ms <= cfg_data;
          CFG_CONSISTENT: consistent_needed <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (ctl.apply) begin
        res_ok <= 1'b0;
        res_crc_ok <= 1'b0;
        res_changed <= 1'b0;
        res_check <= CHK_OK;
        res_steady <= '0;
        res_cache_valid <= 1'b0;
        unique case (req_t'(r_req))
          REQ_FRAME: begin
            if (frame_go) begin
              res_ok <= 1'b1;
              slot_rx_total[hit_slot] <= slot_rx_total[hit_slot] + 32'd1;
              if (crc_good) begin
                res_crc_ok <= 1'b1;
                res_changed <= changed;
                slot_bytes[hit_slot] <= (old_bytes & ~mask) | fresh;
                slot_update_time[hit_slot] <= r_now;
                slot_valid[hit_slot] <= 1'b1;
                slot_crc_errors[hit_slot] <= '0;
                slot_consistent[hit_slot] <= cons_new;
                slot_online[hit_slot] <= 1'b1;
                res_steady <= cons_new;
                res_cache_valid <= 1'b1;
              end else begin
                slot_crc_total[hit_slot] <= slot_crc_total[hit_slot] + 32'd1;
                slot_crc_errors[hit_slot] <= err_new;
                res_steady <= cons_old;
                if (err_new >= crc_error_limit) begin
                  slot_valid[hit_slot] <= 1'b0;
                  res_cache_valid <= 1'b0;
                end else res_cache_valid <= slot_valid[hit_slot];
              end
            end else if (hit && r_fid_match) begin
              res_steady <= cons_old;
              res_cache_valid <= slot_valid[hit_slot];
            end
          end
          REQ_ADD: begin
            if (hit) begin
              res_steady <= cons_old;
              res_cache_valid <= slot_valid[hit_slot];
            end else if (has_free) begin
              slot_used[free_slot] <= 1'b1;
              slot_module_id[free_slot] <= r_target;
              slot_valid[free_slot] <= 1'b0;
              slot_online[free_slot] <= 1'b0;
              slot_bytes[free_slot] <= '0;
              slot_consistent[free_slot] <= '0;
              slot_crc_errors[free_slot] <= '0;
              slot_update_time[free_slot] <= '0;
              slot_rx_total[free_slot] <= '0;
              slot_crc_total[free_slot] <= '0;
              used_count <= used_count + CountW'(1);
              res_ok <= 1'b1;
            end
          end
          REQ_REMOVE: begin
            if (hit) begin
              slot_used[hit_slot] <= 1'b0;
              slot_valid[hit_slot] <= 1'b0;
              slot_online[hit_slot] <= 1'b0;
              slot_bytes[hit_slot] <= '0;
              slot_consistent[hit_slot] <= '0;
              slot_crc_errors[hit_slot] <= '0;
              slot_update_time[hit_slot] <= '0;
              slot_rx_total[hit_slot] <= '0;
              slot_crc_total[hit_slot] <= '0;
              if (used_count != '0) used_count <= used_count - CountW'(1);
              res_ok <= 1'b1;
            end
          end
          REQ_QUERY: begin
            if (!hit) res_check <= CHK_NO_MODULE;
            else begin
              res_steady <= cons_old;
              res_cache_valid <= slot_valid[hit_slot];
              if (!slot_online[hit_slot]) res_check <= CHK_OFFLINE;
              else if (!slot_valid[hit_slot]) res_check <= CHK_NOT_VALID;
              else if (age > stale_limit_ms) res_check <= CHK_STALE;
              else if (cons_old < consistent_needed) res_check <= CHK_INCONSISTENT;
              else res_check <= CHK_OK;
            end
          end
          default: ;
        endcase
      end
      // Load the result beat once the previous one has left
      if (ctl.out_load) begin
        ok <= res_ok;
        crc_ok <= res_crc_ok;
        bytes_changed <= res_changed;
        steady_count <= res_steady;
        cache_valid <= res_cache_valid;
        check_result <= res_check;
        module_count <= 4'(used_count);
      end
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(used_count) == $countones(slot_used)) else $error("count drift");
  a_valid_used: assert property (@(posedge clk) disable iff (rst)
    (slot_valid & ~slot_used) == '0) else $error("valid on free slot");
  a_crcok_ok: assert property (@(posedge clk) disable iff (rst)
    crc_ok |-> ok) else $error("crc_ok without ok");
endmodule
`default_nettype wire

// ----- design/module_frame_check_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Module frame check cache: a table of up to eight registered modules, each
// caching six data bytes from CRC-8 protected data frames, with add, remove
// and consistency query requests. One request is handled at a time: after
// accept it passes through table lookup, the byte-serial CRC unit (one
// step per byte ahead of the CRC byte, length field clamped to 8, at most
// seven bytes, run on every request type), the table update and the result
// register load. A new request is taken the cycle after its predecessor's
// result is loaded; it waits before its own result load while that result
// is still unaccepted. The user must write configuration only while idle;
// the block itself does not enforce it.
module module_frame_check_cache (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  mfcc_req_if.sink req,
  mfcc_rsp_if.source rsp
);
  import mfcc_pkg::*;
  ctl_t ctl;
  sts_t sts;

  mfcc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts, .ctl
  );

  mfcc_dp u_dp (
    .clk, .rst, .ctl, .sts,
    .cfg_we, .cfg_index, .cfg_data,
    .req_type(req.req_type), .target_module(req.target_module),
    .frame_id(req.frame_id), .frame_len(req.frame_len),
    .payload(req.payload), .time_now(req.time_now),
    .ok(rsp.ok), .crc_ok(rsp.crc_ok), .bytes_changed(rsp.bytes_changed),
    .steady_count(rsp.steady_count), .cache_valid(rsp.cache_valid),
    .check_result(rsp.check_result), .module_count(rsp.module_count)
  );
endmodule
`default_nettype wire

// ----- bench/module_frame_check_cache_tb.sv -----
`timescale 1ns / 1ps
module module_frame_check_cache_tb;
  import mfcc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  mfcc_req_if req ();
  mfcc_rsp_if rsp ();

  module_frame_check_cache DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic ok;
    logic crc_ok;
    logic bytes_changed;
    logic [7:0] steady_count;
    logic cache_valid;
    logic [2:0] check_result;
    logic [3:0] module_count;
  } answer_t;

  typedef struct {
    req_t kind;
    logic [7:0] target;
    logic [10:0] fid;
    logic [3:0] flen;
    logic [63:0] data;
    logic [31:0] now;
    logic fixed;
    answer_t want;
  } request_t;

  // Shadow of the block's table and registers
  logic [10:0] frame_id_reg;
  logic [7:0] crc_limit_reg;
  logic [31:0] stale_reg;
  logic [7:0] needed_reg;
  logic used_q [MaxModules];
  logic [7:0] id_q [MaxModules];
  logic valid_q [MaxModules];
  logic online_q [MaxModules];
  logic [47:0] bytes_q [MaxModules];
  logic [7:0] cons_q [MaxModules];
  logic [7:0] errs_q [MaxModules];
  logic [31:0] stamp_q [MaxModules];
  int unsigned used_n;

  answer_t answers_due [$];
  answer_t fixed_due [$];
  logic fixed_flag [$];
  int errors = 0;
  int unsigned cycle = 0;
  bit rsp_idle_on = 1'b1;
  bit req_idle_on = 1'b1;
  int hold_off = 0;
  logic [7:0] live_ids [$];

  function automatic logic [7:0] frame_crc(logic [63:0] d, int n);
    logic [7:0] c;
    c = 8'hFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ d[8*i +: 8];
      for (int b = 0; b < 8; b++) c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic int find_slot(logic [7:0] id);
    for (int k = 0; k < MaxModules; k++) if (used_q[k] && id_q[k] == id) return k;
    return -1;
  endfunction

  function automatic void wipe_slot(int k);
    used_q[k] = 0; id_q[k] = 0; valid_q[k] = 0; online_q[k] = 0;
    bytes_q[k] = 0; cons_q[k] = 0; errs_q[k] = 0; stamp_q[k] = 0;
  endfunction

  // Compute the answer of one request and advance the shadow table
  function automatic answer_t cache_answer(request_t r);
    answer_t a;
    int k, len, dlen;
    logic [47:0] mask, fresh;
    a = '0;
    k = -1;
    case (r.kind)
      REQ_FRAME: if (r.fid == frame_id_reg) begin
        len = (r.flen > 8) ? 8 : r.flen;
        k = find_slot(r.data[7:0]);
        if (k >= 0 && len >= 2) begin
          a.ok = 1;
          if (r.data[8*(len-1) +: 8] == frame_crc(r.data, len - 1)) begin
            dlen = len - 2;
            mask = '0;
            for (int i = 0; i < dlen; i++) mask[8*i +: 8] = 8'hFF;
            fresh = r.data[55:8] & mask;
            a.crc_ok = 1;
            a.bytes_changed = valid_q[k] && dlen > 0 && ((bytes_q[k] ^ fresh) & mask) != 0;
            bytes_q[k] = (bytes_q[k] & ~mask) | fresh;
            stamp_q[k] = r.now;
            valid_q[k] = 1;
            errs_q[k] = 0;
            if (a.bytes_changed) cons_q[k] = 1;
            else if (cons_q[k] != 8'hFF) cons_q[k]++;
            online_q[k] = 1;
          end else begin
            if (errs_q[k] != 8'hFF) errs_q[k]++;
            if (errs_q[k] >= crc_limit_reg) valid_q[k] = 0;
          end
        end
      end
      REQ_ADD: begin
        k = find_slot(r.target);
        if (k < 0 && used_n < MaxModules) begin
          for (int j = 0; j < MaxModules; j++) if (!used_q[j] && k < 0) k = j;
          wipe_slot(k);
          used_q[k] = 1; id_q[k] = r.target; used_n++;
          a.ok = 1;
        end
      end
      REQ_REMOVE: begin
        k = find_slot(r.target);
        if (k >= 0) begin
          wipe_slot(k);
          used_n--;
          a.ok = 1;
          k = -1;
        end
      end
      default: begin
        k = find_slot(r.target);
        if (k < 0) a.check_result = CHK_NO_MODULE;
        else if (!online_q[k]) a.check_result = CHK_OFFLINE;
        else if (!valid_q[k]) a.check_result = CHK_NOT_VALID;
        else if (r.now - stamp_q[k] > stale_reg) a.check_result = CHK_STALE;
        else if (cons_q[k] < needed_reg) a.check_result = CHK_INCONSISTENT;
        else a.check_result = CHK_OK;
      end
    endcase
    if (k >= 0) begin
      a.steady_count = cons_q[k];
      a.cache_valid = valid_q[k];
    end
    a.module_count = used_n[3:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle);
  endtask

  // Write one register, idle only
  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_ID: frame_id_reg = v[10:0];
      CFG_CRC_LIMIT: crc_limit_reg = v[7:0];
      CFG_STALE: stale_reg = v;
      default: needed_reg = v[7:0];
    endcase
  endtask

  // Stop offering and wait for every result
  task automatic drain;
    req.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Offer one beat and hold it until accepted
  task automatic send(request_t r);
    if (req_idle_on && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= r.kind; req.target_module <= r.target; req.frame_id <= r.fid;
    req.frame_len <= r.flen; req.payload <= r.data; req.time_now <= r.now;
    do @(posedge clk); while (!req.ready);
    answers_due.push_back(cache_answer(r));
    fixed_flag.push_back(r.fixed);
    fixed_due.push_back(r.want);
  endtask

  function automatic request_t make_req(req_t kind, logic [7:0] tgt, logic [10:0] fid,
                                        logic [3:0] flen, logic [63:0] d, logic [31:0] now);
    request_t r;
    r.kind = kind; r.target = tgt; r.fid = fid; r.flen = flen; r.data = d; r.now = now;
    r.fixed = 0; r.want = '0;
    return r;
  endfunction

  // Build a frame for module id with a correct or broken CRC
  function automatic request_t make_frame(logic [7:0] id, int len, bit good, logic [31:0] now,
                                          logic [47:0] body);
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[7:0] = id;
    if (len >= 2) d[8 +: 48] = (len > 2) ? body : d[8 +: 48];
    if (len >= 2) begin
      if (len > 2) for (int i = 1; i < len - 1; i++) d[8*i +: 8] = body[8*(i-1) +: 8];
      d[8*(len-1) +: 8] = frame_crc(d, len - 1) ^ (good ? 8'h00 : 8'h01 << $urandom_range(0, 7));
    end
    return make_req(REQ_FRAME, 8'h00, frame_id_reg,
                    (len == 8 && $urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15)) : 4'(len),
                    d, now);
  endfunction

  // Receiver: random stalls, compare each beat
  initial begin
    answer_t got, want, pinned;
    bit pin;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        got = {rsp.ok, rsp.crc_ok, rsp.bytes_changed, rsp.steady_count, rsp.cache_valid,
               rsp.check_result, rsp.module_count};
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = answers_due.pop_front();
          pin = fixed_flag.pop_front();
          pinned = fixed_due.pop_front();
          if (pin && pinned != want) report_mismatch("table row", pinned, want);
          if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
          if (got.crc_ok !== want.crc_ok) report_mismatch("crc_ok", got.crc_ok, want.crc_ok);
          if (got.bytes_changed !== want.bytes_changed)
            report_mismatch("bytes_changed", got.bytes_changed, want.bytes_changed);
          if (got.steady_count !== want.steady_count)
            report_mismatch("steady_count", got.steady_count, want.steady_count);
          if (got.cache_valid !== want.cache_valid)
            report_mismatch("cache_valid", got.cache_valid, want.cache_valid);
          if (got.check_result !== want.check_result)
            report_mismatch("check_result", got.check_result, want.check_result);
          if (got.module_count !== want.module_count)
            report_mismatch("module_count", got.module_count, want.module_count);
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        rsp.ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
        hold_off = $urandom_range(0, 4);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    request_t table_rows [$];
    request_t r;
    logic [7:0] id;
    int len, pick;
    logic [31:0] now;
    req.valid = 1'b0; req.req_type = REQ_FRAME; req.target_module = '0; req.frame_id = '0;
    req.frame_len = '0; req.payload = '0; req.time_now = '0;
    frame_id_reg = 0; crc_limit_reg = 3; stale_reg = 1000; needed_reg = 3;
    for (int k = 0; k < MaxModules; k++) wipe_slot(k);
    used_n = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at reset settings
    r = make_req(REQ_QUERY, 8'hFF, 0, 0, 0, 0); r.fixed = 1;
    r.want = '0; r.want.check_result = CHK_NO_MODULE; table_rows.push_back(r);
    r = make_req(REQ_REMOVE, 8'h00, 0, 0, 0, 0); r.fixed = 1; r.want = '0;
    table_rows.push_back(r);
    for (int i = 0; i < 8; i++) begin
      r = make_req(REQ_ADD, (i == 7) ? 8'hFF : 8'(i), 0, 0, 0, 0); r.fixed = 1;
      r.want = '0; r.want.ok = 1; r.want.module_count = 4'(i + 1); table_rows.push_back(r);
    end
    r = make_req(REQ_ADD, 8'h40, 0, 0, 0, 0); r.fixed = 1;
    r.want = '0; r.want.module_count = 8; table_rows.push_back(r);
    r = make_req(REQ_ADD, 8'h03, 0, 0, 0, 0); r.fixed = 1;
    r.want = '0; r.want.module_count = 8; table_rows.push_back(r);
    r = make_req(REQ_QUERY, 8'hFF, 0, 0, 0, 0); r.fixed = 1;
    r.want = '0; r.want.check_result = CHK_OFFLINE; r.want.module_count = 8;
    table_rows.push_back(r);
    foreach (table_rows[i]) send(table_rows[i]);
    send(make_frame(8'h01, 8, 1, 32'd5, 48'hFFFF_FFFF_FFFF));
    send(make_frame(8'h01, 8, 1, 32'd6, 48'hFFFF_FFFF_FFFF));
    send(make_frame(8'h01, 2, 1, 32'd7, 48'h0));
    send(make_frame(8'h01, 1, 1, 32'd7, 48'h0));
    send(make_frame(8'h01, 8, 0, 32'd8, 48'h0));
    send(make_frame(8'h01, 8, 1, 32'd9, 48'h0));
    send(make_req(REQ_QUERY, 8'h01, 0, 0, 0, 32'd9));
    send(make_req(REQ_QUERY, 8'h01, 0, 0, 0, 32'hFFFF_FFFF));
    send(make_req(REQ_FRAME, 8'h00, 11'h7FF, 4'hF, 64'hFFFF_FFFF_FFFF_FF01, 0));
    send(make_req(REQ_REMOVE, 8'hFF, 0, 0, 0, 0));
    drain();

    // Random phases across register settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_CRC_LIMIT, 0); write_reg(CFG_STALE, 0);
                 write_reg(CFG_CONSISTENT, 0); end
        1: begin write_reg(CFG_FRAME_ID, 11'h7FF); write_reg(CFG_CRC_LIMIT, 255);
                 write_reg(CFG_STALE, 32'hFFFF_FFFF); write_reg(CFG_CONSISTENT, 255); end
        2: begin write_reg(CFG_FRAME_ID, 11'h123); write_reg(CFG_CRC_LIMIT, 1);
                 write_reg(CFG_STALE, 50); write_reg(CFG_CONSISTENT, 2); end
        default: begin write_reg(CFG_FRAME_ID, 11'($urandom));
                 write_reg(CFG_CRC_LIMIT, $urandom_range(1, 6));
                 write_reg(CFG_STALE, $urandom_range(10, 300));
                 write_reg(CFG_CONSISTENT, $urandom_range(0, 6)); end
      endcase
      if (phase == 2) hold_off = 300;
      if (phase == 5) begin req_idle_on = 0; rsp_idle_on = 0; end
      now = $urandom;
      for (int n = 0; n < 275; n++) begin
        now += $urandom_range(0, 40);
        live_ids.delete();
        for (int k = 0; k < MaxModules; k++) if (used_q[k]) live_ids.push_back(id_q[k]);
        id = (live_ids.size() != 0 && $urandom_range(0, 9) != 0)
             ? live_ids[$urandom_range(0, live_ids.size() - 1)] : 8'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) id = ($urandom_range(0, 20) == 0) ? 8'($urandom) : id;
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(7, 8);
          r = make_frame(id, len, $urandom_range(0, 4) != 0, now,
                         ($urandom_range(0, 2) == 0) ? 48'({$urandom, $urandom})
                                                     : {24'h0, 24'($urandom_range(0, 3))});
          if ($urandom_range(0, 30) == 0) r.fid = 11'($urandom);
        end else if (pick < 14) r = make_req(REQ_ADD, id, 11'($urandom), 4'($urandom),
                                             {$urandom, $urandom}, now);
        else if (pick < 16) r = make_req(REQ_REMOVE, id, 11'($urandom), 4'($urandom),
                                         {$urandom, $urandom}, now);
        else r = make_req(REQ_QUERY, id, 11'($urandom), 4'($urandom), {$urandom, $urandom},
                          now + (($urandom_range(0, 9) == 0) ? $urandom : 0));
        send(r);
        if (n == 100) drain();
      end
      drain();
    end

    if (errors == 0 && answers_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/mfcc_pkg.sv
design/mfcc_if.sv
design/mfcc_ctrl.sv
design/mfcc_dp.sv
design/module_frame_check_cache.sv
bench/module_frame_check_cache_tb.sv
